### design/deq_pkg.sv
// Shared types for the deque with value delete: command codes, status codes
// and the control word broadcast to the storage cells.
// No dependencies.
`default_nettype none

package deq_pkg;

    // Command codes carried by the kind field
    typedef enum logic [3:0] {
        K_PUSH_FRONT  = 4'd0,
        K_PUSH_BACK   = 4'd1,
        K_POP_FRONT   = 4'd2,
        K_POP_BACK    = 4'd3,
        K_CLEAR       = 4'd4,
        K_REMOVE      = 4'd5,
        K_PRINT_ALL   = 4'd6,
        K_PRINT_FIRST = 4'd7,
        K_PRINT_LAST  = 4'd8
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // What every cell does in a cycle
    typedef enum logic [2:0] {
        C_HOLD,
        C_PUSH_FRONT,
        C_PUSH_BACK,
        C_SHIFT_LEFT,
        C_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t   cmd;
        logic [31:0] data;
    } cell_ctl_t;

endpackage

`default_nettype wire

### design/deq_cell.sv
// One storage cell of the deque chain: holds one word and moves it to or
// from its neighbors under the broadcast control word. Depends on deq_pkg.
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int INDEX = 0
) (
    input  wire logic                         clk,
    input  wire cell_ctl_t                    ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   pos,
    input  wire logic [31:0]                  left_data,
    input  wire logic [31:0]                  right_data,
    input  wire logic [31:0]                  head_data,
    output logic      [31:0]                  data,
    output logic                              match
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] IDX  = CW'(INDEX);
    localparam logic [CW-1:0] IDX1 = CW'(INDEX + 1);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    // next word for this cell
    always_comb
    begin
        data_next = data_reg;
        case (ctl.cmd)
            C_PUSH_FRONT:
            begin
                data_next = left_data;
            end
            C_PUSH_BACK:
            begin
                if (pos == IDX)
                begin
                    data_next = ctl.data;
                end
            end
            C_SHIFT_LEFT:
            begin
                if (IDX >= pos)
                begin
                    data_next = right_data;
                end
            end
            C_ROTATE:
            begin
                // last occupied cell wraps the head word around
                if (IDX1 == pos)
                begin
                    data_next = head_data;
                end
                else if (IDX1 < pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == ctl.data);

endmodule

`default_nettype wire

### design/deque_with_value_delete.sv
// Deque with value delete: top level, command sequencer and cell chain.
// Push, pop, clear and unused kinds: status beat registered next cycle.
// Remove value: a pointer step or a delete per occupied entry, then the status beat.
// Print: the chain rotates once per cycle over all occupied entries, holding while a beat
// waits; one beat per cycle while out_ready holds. Next command after the full rotation.
// Reset clears occupancy and control; stored words stay undefined, no clearing pass.
`default_nettype none

module deque_with_value_delete
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         kind,
    input  wire logic signed [31:0] value,
    input  wire logic [7:0]         count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      item,
    output logic                    has_item,
    output logic [1:0]              status,
    output logic                    last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int MW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_PRINT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   occ_reg, occ_next;
    logic [CW-1:0]   p_reg, p_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   start_reg, start_next;
    logic [CW-1:0]   end_reg, end_next;
    logic [31:0]     val_reg, val_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     item_reg, item_next;
    logic            has_item_reg, has_item_next;
    status_t         status_reg, status_next;
    logic            last_reg, last_next;

    cell_ctl_t       ctl;
    logic [CW-1:0]   pos;
    logic [31:0]     cell_data [DEPTH];
    logic [31:0]     left_w    [DEPTH];
    logic [31:0]     right_w   [DEPTH];
    logic [DEPTH-1:0] match_vec;

    logic            out_free;
    logic            accept;

    // cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_w[i] = value;
        end
        else
        begin : g_body
            assign left_w[i] = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w[i] = 32'd0;
        end
        else
        begin : g_inner
            assign right_w[i] = cell_data[i+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .left_data  (left_w[i]),
            .right_data (right_w[i]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // sequencer next state
    always_comb
    begin
        logic [MW-1:0] cnt_ext;
        logic [MW-1:0] occ_ext;
        logic [MW-1:0] cnt_min1;
        logic [MW-1:0] n_ext;
        logic [CW-1:0] n;
        logic [CW-1:0] start;
        logic          emit_en;
        logic [31:0]   emit_item;
        logic          emit_has;
        status_t       emit_st;
        logic          emit_last;
        logic          emit_now;

        state_next     = state_reg;
        occ_next       = occ_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        has_item_next  = has_item_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        ctl.cmd  = C_HOLD;
        ctl.data = (state_reg == S_IDLE) ? value : val_reg;
        pos      = occ_reg;

        cnt_ext  = MW'(count);
        occ_ext  = MW'(occ_reg);
        cnt_min1 = (count == 8'd0) ? MW'(1) : cnt_ext;
        n_ext    = '0;
        n        = '0;
        start    = '0;

        emit_en   = 1'b0;
        emit_item = 32'd0;
        emit_has  = 1'b0;
        emit_st   = ST_OK;
        emit_last = 1'b1;
        emit_now  = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        K_PUSH_FRONT:
                        begin
                            emit_en = 1'b1;
                            if (occ_reg >= FULL_CNT)
                            begin
                                emit_st = ST_FULL;
                            end
                            else
                            begin
                                ctl.cmd  = C_PUSH_FRONT;
                                occ_next = occ_reg + ONE;
                            end
                        end
                        K_PUSH_BACK:
                        begin
                            emit_en = 1'b1;
                            if (occ_reg >= FULL_CNT)
                            begin
                                emit_st = ST_FULL;
                            end
                            else
                            begin
                                ctl.cmd  = C_PUSH_BACK;
                                occ_next = occ_reg + ONE;
                            end
                        end
                        K_POP_FRONT:
                        begin
                            emit_en = 1'b1;
                            if (occ_reg == '0)
                            begin
                                emit_st = ST_EMPTY;
                            end
                            else
                            begin
                                ctl.cmd  = C_SHIFT_LEFT;
                                pos      = '0;
                                occ_next = occ_reg - ONE;
                            end
                        end
                        K_POP_BACK:
                        begin
                            emit_en = 1'b1;
                            if (occ_reg == '0)
                            begin
                                emit_st = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - ONE;
                            end
                        end
                        K_CLEAR:
                        begin
                            emit_en  = 1'b1;
                            occ_next = '0;
                        end
                        K_REMOVE:
                        begin
                            val_next   = value;
                            p_next     = '0;
                            state_next = S_REMOVE;
                        end
                        K_PRINT_ALL, K_PRINT_FIRST, K_PRINT_LAST:
                        begin
                            if (kind_t'(kind) == K_PRINT_ALL)
                            begin
                                n     = occ_reg;
                                start = '0;
                            end
                            else if (kind_t'(kind) == K_PRINT_FIRST)
                            begin
                                n_ext = (cnt_ext < occ_ext) ? cnt_ext : occ_ext;
                                n     = n_ext[CW-1:0];
                                start = '0;
                            end
                            else
                            begin
                                n_ext = (cnt_min1 > occ_ext) ? occ_ext : cnt_min1;
                                n     = n_ext[CW-1:0];
                                start = occ_reg - n;
                            end
                            if (n == '0)
                            begin
                                emit_en = 1'b1;
                            end
                            else
                            begin
                                start_next = start;
                                end_next   = start + n;
                                k_next     = '0;
                                state_next = S_PRINT;
                            end
                        end
                        default:
                        begin
                            emit_en = 1'b1;
                        end
                    endcase
                end
            end

            S_REMOVE:
            begin
                // scan pointer either deletes the matching cell or steps on, then emits the status
                if (p_reg >= occ_reg)
                begin
                    if (out_free)
                    begin
                        emit_en    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (match_vec[p_reg[IW-1:0]])
                begin
                    ctl.cmd  = C_SHIFT_LEFT;
                    pos      = p_reg;
                    occ_next = occ_reg - ONE;
                end
                else
                begin
                    p_next = p_reg + ONE;
                end
            end

            S_PRINT:
            begin
                // rotate once per step, head cell feeds the output
                emit_now = (k_reg >= start_reg) && (k_reg < end_reg);
                if (!emit_now || out_free)
                begin
                    ctl.cmd = C_ROTATE;
                    pos     = occ_reg;
                    if (emit_now)
                    begin
                        emit_en   = 1'b1;
                        emit_item = cell_data[0];
                        emit_has  = 1'b1;
                        emit_last = ((k_reg + ONE) == end_reg);
                    end
                    k_next = k_reg + ONE;
                    if ((k_reg + ONE) == occ_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register load
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            item_next      = emit_item;
            has_item_next  = emit_has;
            status_next    = emit_st;
            last_next      = emit_last;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            p_reg         <= '0;
            k_reg         <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            val_reg       <= '0;
            out_valid_reg <= 1'b0;
            item_reg      <= '0;
            has_item_reg  <= 1'b0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            p_reg         <= p_next;
            k_reg         <= k_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            val_reg       <= val_next;
            out_valid_reg <= out_valid_next;
            item_reg      <= item_next;
            has_item_reg  <= has_item_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign item      = $signed(item_reg);
    assign has_item  = has_item_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_CNT)
        else $error("occupancy above depth");

    a_empty_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_item_reg) |-> last_reg)
        else $error("status beat without last");

    a_print_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRINT) |=> $stable(occ_reg))
        else $error("occupancy changed while printing");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REMOVE) |=> (occ_reg <= $past(occ_reg)))
        else $error("remove grew the queue");

endmodule

`default_nettype wire

### sim/deque_with_value_delete_test.sv
// Self-checking testbench for deque_with_value_delete: directed and random commands,
// with every returned beat checked against a shadow deque kept in the testbench.
// Depends on deq_pkg (design/deq_pkg.sv) and the deque_with_value_delete top level.
`timescale 1ns / 1ps

module deque_with_value_delete_test;
    import deq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_CMDS   = 500;
    localparam int PHASE_CMDS    = 125;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 2 * DEPTH + 8;
    localparam int REPORT_LINES  = 40;

    // kinds with no operation behind them
    localparam logic [3:0] K_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] K_LAST_UNUSED  = 4'd15;

    // idling phases
    localparam int PH_STEADY   = 0;
    localparam int PH_SRC_IDLE = 1;
    localparam int PH_SNK_IDLE = 2;
    localparam int PH_BOTH     = 3;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         count;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] item;
    logic               has_item;
    logic [1:0]         status;
    logic               last;

    int phase;
    int cmds_sent;
    bit hold_req;
    int hold_left;

    // Shadow deque and the store of beats it predicts
    class deque_shadow;
        typedef struct {
            logic signed [31:0] item;
            logic               has_item;
            logic [1:0]         status;
            logic               last;
        } beat_t;

        logic [31:0] contents[$];
        beat_t       expected_beats[$];
        int          mismatches;

        function new();
            contents.delete();
            expected_beats.delete();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < REPORT_LINES)
                $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void add_beat(input logic [31:0] w, input logic h, input logic [1:0] st,
                               input logic l);
            beat_t b;
            b.item     = w;
            b.has_item = h;
            b.status   = st;
            b.last     = l;
            expected_beats.push_back(b);
        endfunction

        // entries first .. first+n-1, front to back; an empty range gives one bare beat
        function void add_print(input int first, input int n);
            if (n == 0)
                add_beat('0, 1'b0, ST_OK, 1'b1);
            else
                for (int i = 0; i < n; i++)
                    add_beat(contents[first + i], 1'b1, ST_OK, i == n - 1);
        endfunction

        // Accepted command: update the shadow and queue its beats
        function void note_command(input logic [3:0] k, input logic [31:0] v,
                                   input logic [7:0] c);
            logic [31:0] kept[$];
            logic [1:0]  st;
            int          n;
            int          occ;

            st  = ST_OK;
            occ = contents.size();
            case (k)
                K_PUSH_FRONT:
                    if (occ >= DEPTH) st = ST_FULL;
                    else contents.push_front(v);
                K_PUSH_BACK:
                    if (occ >= DEPTH) st = ST_FULL;
                    else contents.push_back(v);
                K_POP_FRONT:
                    if (occ == 0) st = ST_EMPTY;
                    else void'(contents.pop_front());
                K_POP_BACK:
                    if (occ == 0) st = ST_EMPTY;
                    else void'(contents.pop_back());
                K_CLEAR:
                    contents.delete();
                K_REMOVE:
                begin
                    foreach (contents[i])
                        if (contents[i] !== v) kept.push_back(contents[i]);
                    contents = kept;
                end
                K_PRINT_ALL:
                begin
                    add_print(0, occ);
                    return;
                end
                K_PRINT_FIRST:
                begin
                    n = (c < occ) ? int'(c) : occ;
                    add_print(0, n);
                    return;
                end
                K_PRINT_LAST:
                begin
                    n = (c == 0) ? 1 : int'(c);
                    if (n > occ) n = occ;
                    add_print(occ - n, n);
                    return;
                end
                default: ;
            endcase
            add_beat('0, 1'b0, st, 1'b1);
        endfunction

        // Accepted result beat: compare with the oldest expectation
        task check_beat(input logic signed [31:0] got_item, input logic got_has,
                        input logic [1:0] got_status, input logic got_last);
            beat_t e;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing expected (item %0d)", got_item));
                return;
            end
            e = expected_beats.pop_front();
            if (got_item !== e.item)
                report_mismatch($sformatf("item %0d, expected %0d", got_item, e.item));
            if (got_has !== e.has_item)
                report_mismatch($sformatf("has_item %b, expected %b", got_has, e.has_item));
            if (got_status !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", got_status, e.status));
            if (got_last !== e.last)
                report_mismatch($sformatf("last %b, expected %b", got_last, e.last));
        endtask
    endclass

    deque_shadow shadow = new();

    deque_with_value_delete #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .value(value),
        .count(count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .item(item),
        .has_item(has_item),
        .status(status),
        .last(last)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive one command beat; returns at the falling edge after it is taken
    task automatic send_command(input logic [3:0] k, input logic [31:0] v,
                                input logic [7:0] c);
        int idle_pct;
        idle_pct = (phase == PH_SRC_IDLE) ? 52 : (phase == PH_BOTH) ? 16 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        count    <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        shadow.note_command(k, v, c);
        cmds_sent++;
        @(negedge clk);
    endtask

    // Words from a small pool make value removal hit often
    function automatic logic [31:0] pool_word();
        case ($urandom_range(4))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return 32'h0000_0005;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        return ($urandom_range(1) == 0) ? pool_word() : $urandom;
    endfunction

    function automatic logic [7:0] pick_count();
        return ($urandom_range(1) == 0) ? 8'($urandom_range(20)) : 8'($urandom_range(255));
    endfunction

    // One command of weighted random kind
    task automatic random_command();
        int          r;
        logic [3:0]  k;
        r = $urandom_range(99);
        if (r < 22)      k = K_PUSH_FRONT;
        else if (r < 44) k = K_PUSH_BACK;
        else if (r < 54) k = K_POP_FRONT;
        else if (r < 64) k = K_POP_BACK;
        else if (r < 66) k = K_CLEAR;
        else if (r < 74) k = K_REMOVE;
        else if (r < 80) k = K_PRINT_ALL;
        else if (r < 86) k = K_PRINT_FIRST;
        else if (r < 93) k = K_PRINT_LAST;
        else             k = 4'($urandom_range(K_FIRST_UNUSED, K_LAST_UNUSED));
        send_command(k, pick_word(), pick_count());
    endtask

    // Result side: check accepted beats, stall per phase, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                shadow.check_beat(item, has_item, status, last);
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (phase == PH_SNK_IDLE)
                out_ready <= ($urandom_range(99) >= 52);
            else if (phase == PH_BOTH)
                out_ready <= ($urandom_range(99) >= 16);
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: too long with no beat on either side ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial
    begin
        int r;
        phase     = PH_STEADY;
        cmds_sent = 0;
        hold_req  = 1'b0;
        hold_left = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = K_PUSH_FRONT;
        value     = '0;
        count     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, every kind, empty and unused cases
        send_command(K_PUSH_BACK,   32'h8000_0000, 8'd0);
        send_command(K_PUSH_FRONT,  32'h7fff_ffff, 8'd0);
        send_command(K_PUSH_BACK,   32'h0000_0000, 8'd0);
        send_command(K_PUSH_BACK,   32'hffff_ffff, 8'd0);
        send_command(K_PUSH_BACK,   32'h8000_0000, 8'd0);
        send_command(K_PRINT_ALL,   32'h0,         8'd0);
        send_command(K_PRINT_FIRST, 32'h0,         8'd0);
        send_command(K_PRINT_FIRST, 32'h0,         8'd2);
        send_command(K_PRINT_FIRST, 32'h0,         8'd255);
        send_command(K_PRINT_LAST,  32'h0,         8'd0);
        send_command(K_PRINT_LAST,  32'h0,         8'd255);
        send_command(K_REMOVE,      32'h8000_0000, 8'd0);
        send_command(K_REMOVE,      32'h1234_5678, 8'd0);
        send_command(K_POP_FRONT,   32'h0,         8'd0);
        send_command(K_POP_BACK,    32'h0,         8'd0);
        send_command(K_PRINT_ALL,   32'h0,         8'd0);
        send_command(K_CLEAR,       32'h0,         8'd0);
        send_command(K_POP_FRONT,   32'h0,         8'd0);
        send_command(K_POP_BACK,    32'h0,         8'd0);
        send_command(K_PRINT_ALL,   32'h0,         8'd0);
        send_command(K_PRINT_LAST,  32'h0,         8'd3);
        send_command(K_REMOVE,      32'h0,         8'd0);
        send_command(K_FIRST_UNUSED, 32'hffff_ffff, 8'hff);
        send_command(K_LAST_UNUSED, 32'h0,         8'd0);

        // result side holds off while commands keep coming
        hold_req  = 1'b1;
        cmds_sent = 0;

        // random bursts; the idling phase steps every PHASE_CMDS commands
        while (cmds_sent < RANDOM_CMDS)
        begin
            phase = (cmds_sent / PHASE_CMDS > PH_BOTH) ? PH_BOTH : cmds_sent / PHASE_CMDS;
            r = $urandom_range(99);
            if (r < 55)
                repeat (8) random_command();
            else if (r < 70)
            begin
                // fill past full
                repeat (DEPTH + 2)
                    send_command($urandom_range(1) ? K_PUSH_BACK : K_PUSH_FRONT,
                                 pick_word(), pick_count());
                send_command(K_PRINT_ALL, pick_word(), pick_count());
            end
            else if (r < 80)
            begin
                // pop six entries, running past empty when few are held
                repeat (6)
                    send_command($urandom_range(1) ? K_POP_BACK : K_POP_FRONT,
                                 pick_word(), pick_count());
            end
            else if (r < 92)
            begin
                // pooled words, then remove a pooled word and print
                repeat (6)
                    send_command($urandom_range(1) ? K_PUSH_BACK : K_PUSH_FRONT,
                                 pool_word(), pick_count());
                send_command(K_REMOVE, pool_word(), pick_count());
                send_command(K_PRINT_ALL, pick_word(), pick_count());
            end
            else
            begin
                repeat (4)
                    send_command($urandom_range(1) ? K_PRINT_LAST : K_PRINT_FIRST,
                                 pick_word(), pick_count());
            end
        end
        in_valid <= 1'b0;

        // let the last beats come back, then watch for strays
        while (shadow.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
